FILE: design/wsfd_pkg.sv
package wsfd_pkg;

  // Default width of the extended payload length and of the payload counter.
  localparam int unsigned LENGTH_BITS_DEFAULT = 64;

  // Width of the payload_length result field.
  localparam int unsigned PAYLOAD_LENGTH_W = 64;

  // Base length codes that select an extended length field.
  localparam logic [6:0] BASE_LEN_EXT16 = 7'd126;
  localparam logic [6:0] BASE_LEN_EXT64 = 7'd127;

  // Extended length byte counts and masking key size.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] BASE_HDR_BYTES = 4'd2;

  // Header positions of the two fixed header bytes.
  localparam logic [3:0] HDR_POS_BYTE0 = 4'd0;
  localparam logic [3:0] HDR_POS_BYTE1 = 4'd1;

  typedef enum logic {
    CMD_DATA  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_HEADER  = 2'd0,
    CLS_PAYLOAD = 2'd1,
    CLS_CLEARED = 2'd2,
    CLS_DROPPED = 2'd3
  } byte_class_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [1:0]                  byte_class;
    logic [7:0]                  data_out;
    logic                        fin;
    logic [2:0]                  rsv_bits;
    logic [3:0]                  opcode;
    logic                        masked;
    logic [PAYLOAD_LENGTH_W-1:0] payload_length;
    logic                        frame_end;
  } result_t;

endpackage

FILE: design/wsfd_in_if.sv
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

FILE: design/wsfd_out_if.sv
interface wsfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_class;
  logic [7:0]  data_out;
  logic        fin;
  logic [2:0]  rsv_bits;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic        frame_end;

  modport source (output valid, output byte_class, output data_out, output fin,
                  output rsv_bits, output opcode, output masked,
                  output payload_length, output frame_end, input ready);
  modport sink   (input valid, input byte_class, input data_out, input fin,
                  input rsv_bits, input opcode, input masked,
                  input payload_length, input frame_end, output ready);
endinterface

FILE: design/wsfd_parser.sv
module wsfd_parser #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  wsfd_pkg::item_t   item,
  output wsfd_pkg::result_t result
);

  logic [3:0]             hdr_pos_r,   hdr_pos_nxt;
  logic                   fin_r,       fin_nxt;
  logic [2:0]             rsv_r,       rsv_nxt;
  logic [3:0]             opcode_r,    opcode_nxt;
  logic                   mask_r,      mask_nxt;
  logic [6:0]             base_len_r,  base_len_nxt;
  logic [LENGTH_BITS-1:0] ext_len_r,   ext_len_nxt;
  logic [7:0]             key_r [4];
  logic [7:0]             key_nxt [4];
  logic [LENGTH_BITS-1:0] pay_cnt_r,   pay_cnt_nxt;
  logic                   done_r,      done_nxt;

  logic [3:0]             ext_bytes;
  logic [3:0]             ext_end;
  logic [3:0]             hdr_len;
  logic [3:0]             hdr_pos_inc;
  logic [3:0]             key_pos;
  logic [LENGTH_BITS-1:0] cur_len_nxt;
  logic [LENGTH_BITS-1:0] pay_cnt_inc;
  logic [LENGTH_BITS-1:0] ext_shifted;
  logic [7:0]             b;
  logic [1:0]             cls;
  logic [7:0]             dout;
  logic                   frame_end;

  assign b = item.data_in;

  // Header layout follows from the stored mask flag and base length.
  always_comb begin
    case (base_len_r)
      wsfd_pkg::BASE_LEN_EXT16: ext_bytes = wsfd_pkg::EXT16_BYTES;
      wsfd_pkg::BASE_LEN_EXT64: ext_bytes = wsfd_pkg::EXT64_BYTES;
      default:                  ext_bytes = 4'd0;
    endcase
  end

  assign ext_end     = wsfd_pkg::BASE_HDR_BYTES + ext_bytes;
  assign hdr_len     = ext_end + (mask_r ? wsfd_pkg::KEY_BYTES : 4'd0);
  assign hdr_pos_inc = hdr_pos_r + 4'd1;
  assign key_pos     = hdr_pos_r - ext_end;
  assign pay_cnt_inc = pay_cnt_r + LENGTH_BITS'(1);
  assign ext_shifted = {ext_len_r[LENGTH_BITS-9:0], b};

  always_comb begin
    hdr_pos_nxt  = hdr_pos_r;
    fin_nxt      = fin_r;
    rsv_nxt      = rsv_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    base_len_nxt = base_len_r;
    ext_len_nxt  = ext_len_r;
    key_nxt      = key_r;
    pay_cnt_nxt  = pay_cnt_r;
    cls          = wsfd_pkg::CLS_HEADER;
    dout         = 8'd0;
    frame_end    = 1'b0;

    if (item.cmd == wsfd_pkg::CMD_CLEAR) begin
      hdr_pos_nxt  = '0;
      fin_nxt      = 1'b0;
      rsv_nxt      = '0;
      opcode_nxt   = '0;
      mask_nxt     = 1'b0;
      base_len_nxt = '0;
      ext_len_nxt  = '0;
      for (int i = 0; i < 4; i++) key_nxt[i] = '0;
      pay_cnt_nxt  = '0;
      cls          = wsfd_pkg::CLS_CLEARED;
    end else if (done_r) begin
      cls = wsfd_pkg::CLS_DROPPED;
    end else if (hdr_pos_r == wsfd_pkg::HDR_POS_BYTE0) begin
      fin_nxt     = b[7];
      rsv_nxt     = b[6:4];
      opcode_nxt  = b[3:0];
      hdr_pos_nxt = wsfd_pkg::HDR_POS_BYTE1;
    end else if (hdr_pos_r == wsfd_pkg::HDR_POS_BYTE1) begin
      mask_nxt     = b[7];
      base_len_nxt = b[6:0];
      hdr_pos_nxt  = wsfd_pkg::BASE_HDR_BYTES;
      // Only an unmasked frame with a zero base length ends here.
      frame_end    = !b[7] && (b[6:0] == 7'd0);
    end else if (hdr_pos_r < hdr_len) begin
      if (hdr_pos_r < ext_end) begin
        ext_len_nxt = ext_shifted;
      end else begin
        key_nxt[key_pos[1:0]] = b;
      end
      hdr_pos_nxt = hdr_pos_inc;
      frame_end   = (hdr_pos_inc == hdr_len) && (cur_len_nxt == '0);
    end else begin
      cls         = wsfd_pkg::CLS_PAYLOAD;
      dout        = mask_r ? (b ^ key_r[pay_cnt_r[1:0]]) : b;
      pay_cnt_nxt = pay_cnt_inc;
      frame_end   = (pay_cnt_inc == cur_len_nxt);
    end
  end

  // Length seen after this byte's update.
  assign cur_len_nxt = (base_len_nxt < wsfd_pkg::BASE_LEN_EXT16)
                       ? LENGTH_BITS'(base_len_nxt) : ext_len_nxt;

  assign done_nxt = (item.cmd == wsfd_pkg::CMD_CLEAR) ? 1'b0 : (done_r | frame_end);

  always_comb begin
    result.byte_class     = cls;
    result.data_out       = dout;
    result.fin            = fin_nxt;
    result.rsv_bits       = rsv_nxt;
    result.opcode         = opcode_nxt;
    result.masked         = mask_nxt;
    result.payload_length = wsfd_pkg::PAYLOAD_LENGTH_W'(cur_len_nxt);
    result.frame_end      = frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r  <= '0;
      fin_r      <= 1'b0;
      rsv_r      <= '0;
      opcode_r   <= '0;
      mask_r     <= 1'b0;
      base_len_r <= '0;
      ext_len_r  <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      pay_cnt_r  <= '0;
      done_r     <= 1'b0;
    end else if (step) begin
      hdr_pos_r  <= hdr_pos_nxt;
      fin_r      <= fin_nxt;
      rsv_r      <= rsv_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      base_len_r <= base_len_nxt;
      ext_len_r  <= ext_len_nxt;
      key_r      <= key_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

FILE: design/websocket_frame_deframer_unit.sv
// WebSocket frame deframer, one received byte per transaction.
// Input channel in_chan carries cmd and data_in: a data byte is parsed as part
// of the current frame, a clear command restarts the parse from header byte 0.
// Output channel out_chan returns exactly one result per input transaction:
// the class of the byte (header, payload, cleared, dropped after frame end),
// the unmasked payload byte, the stored header fields, the decoded payload
// length and a flag on the byte that completes the frame.
// A transaction accepted at one edge has its result registered and offered
// on out_chan from the next cycle. One byte is taken per cycle while out_chan
// is not stalled; the parser state update is a single pass whose longest
// path is the LENGTH_BITS-wide payload counter increment and length compare.
// The result sits in an output register; a new byte is accepted whenever that
// register is empty or is being emptied in the same cycle, so a stalled
// receiver holds the result stable and back-pressures in_chan after one
// transaction. Reset (synchronous, rst_n low) returns the parser to the start
// of a frame with all stored header fields zero and empties the output.
module websocket_frame_deframer_unit #(
  parameter int unsigned LENGTH_BITS = wsfd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  wsfd_in_if.sink    in_chan,
  wsfd_out_if.source out_chan
);

  logic              in_accept;
  logic              out_valid_r, out_valid_nxt;
  wsfd_pkg::item_t   item;
  wsfd_pkg::result_t result;
  wsfd_pkg::result_t result_r;

  // The output register frees up when it is empty or its result is taken now.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign item.cmd     = in_chan.cmd;
  assign item.data_in = in_chan.data_in;

  // Parser holds the frame state and works out the result of this byte.
  wsfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_accept),
    .item   (item),
    .result (result)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset: it is only looked at while valid is high.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.byte_class     = result_r.byte_class;
  assign out_chan.data_out       = result_r.data_out;
  assign out_chan.fin            = result_r.fin;
  assign out_chan.rsv_bits       = result_r.rsv_bits;
  assign out_chan.opcode         = result_r.opcode;
  assign out_chan.masked         = result_r.masked;
  assign out_chan.payload_length = result_r.payload_length;
  assign out_chan.frame_end      = result_r.frame_end;

endmodule

FILE: sim/websocket_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the WebSocket frame deframer.
// Bytes are pushed through the input channel one transaction at a time. Each
// accepted byte is also run through a behavioural copy of the parser held in
// this module, and the copy's answer is queued. The result channel is watched
// at every rising edge, and each result transaction is compared, field by
// field, with the oldest queued answer.
module websocket_frame_deframer_unit_tb;
  import wsfd_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  // How the payload length of a generated frame is encoded in its header.
  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  localparam int unsigned ITEMS_PER_PHASE = 217;
  localparam int unsigned MAX_REPORTS     = 10;

  logic clk = 1'b0;
  logic rst_n;

  wsfd_in_if  in_if ();
  wsfd_out_if out_if ();

  websocket_frame_deframer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle rates, in per cent, for the sending and the receiving side. The
  // stimulus sequence changes them between phases.
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  // Parser state as the bench believes it to be.
  logic [3:0]  parse_pos;
  logic        held_fin;
  logic [2:0]  held_rsv;
  logic [3:0]  held_opcode;
  logic        held_mask;
  logic [6:0]  base_len;
  logic [63:0] ext_len;
  logic [7:0]  mask_key [4];
  logic [63:0] pay_count;
  logic        frame_closed;

  // Results the block owes us, oldest first.
  result_t     awaited_results [$];
  // Bytes that the parser actually acted on (dropped bytes are left out).
  int unsigned parsed_bytes  = 0;
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Behavioural parser
  // ---------------------------------------------------------------------------

  // Number of extended length bytes announced by the base length.
  function automatic logic [3:0] ext_count();
    if (base_len == BASE_LEN_EXT16) return EXT16_BYTES;
    if (base_len == BASE_LEN_EXT64) return EXT64_BYTES;
    return 4'd0;
  endfunction

  // The short length is used directly; the two escape codes switch over to
  // whatever has been gathered in the extended length so far.
  function automatic logic [63:0] decoded_length();
    return (base_len < BASE_LEN_EXT16) ? 64'(base_len) : ext_len;
  endfunction

  task automatic clear_parser();
    parse_pos    = HDR_POS_BYTE0;
    held_fin     = 1'b0;
    held_rsv     = 3'd0;
    held_opcode  = 4'd0;
    held_mask    = 1'b0;
    base_len     = 7'd0;
    ext_len      = 64'd0;
    mask_key     = '{default: 8'h00};
    pay_count    = 64'd0;
    frame_closed = 1'b0;
  endtask

  // Works out the result of one accepted byte and queues it.
  task automatic deframe_byte(input cmd_t c, input logic [7:0] b);
    result_t    r;
    logic [3:0] hdr_len;
    logic [3:0] ext_stop;
    logic       ends;
    r    = '0;
    ends = 1'b0;
    if (c == CMD_CLEAR) begin
      clear_parser();
      r.byte_class = CLS_CLEARED;
    end else begin
      ext_stop     = BASE_HDR_BYTES + ext_count();
      hdr_len      = ext_stop + (held_mask ? KEY_BYTES : 4'd0);
      r.byte_class = CLS_HEADER;
      if (frame_closed) begin
        // Anything after the end of the frame is thrown away until a clear.
        r.byte_class = CLS_DROPPED;
      end else if (parse_pos == HDR_POS_BYTE0) begin
        {held_fin, held_rsv, held_opcode} = b;
        parse_pos = HDR_POS_BYTE1;
      end else if (parse_pos == HDR_POS_BYTE1) begin
        held_mask = b[7];
        base_len  = b[6:0];
        parse_pos = BASE_HDR_BYTES;
        // Only an unmasked frame with a short length of zero ends here.
        ends = !held_mask && (base_len == 7'd0);
      end else if (parse_pos < hdr_len) begin
        if (parse_pos < ext_stop) begin
          // Big-endian length: older bytes shift towards the top and fall off.
          ext_len = {ext_len[55:0], b};
        end else begin
          mask_key[2'(parse_pos - ext_stop)] = b;
        end
        parse_pos = parse_pos + 4'd1;
        ends = (parse_pos == hdr_len) && (decoded_length() == 64'd0);
      end else begin
        r.byte_class = CLS_PAYLOAD;
        r.data_out   = held_mask ? (b ^ mask_key[pay_count[1:0]]) : b;
        pay_count    = pay_count + 64'd1;
        ends         = (pay_count == decoded_length());
      end
      if (ends) frame_closed = 1'b1;
      r.fin            = held_fin;
      r.rsv_bits       = held_rsv;
      r.opcode         = held_opcode;
      r.masked         = held_mask;
      r.payload_length = decoded_length();
      r.frame_end      = ends;
    end
    if (r.byte_class != CLS_DROPPED) parsed_bytes++;
    awaited_results.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Every failure passes through here; only the first few are printed.
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: mismatch in %s: expected %0h, got %0h",
               $time, what, want, got);
  endtask

  // The result register is sampled at the rising edge, before the block's own
  // updates for that edge take effect, so the values seen are the ones that
  // the handshake actually moved.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.byte_class, out_if.data_out, out_if.fin, out_if.rsv_bits,
             out_if.opcode, out_if.masked, out_if.payload_length,
             out_if.frame_end};
      if (awaited_results.size() == 0) begin
        report_mismatch("unawaited result, byte_class", 64'd0, 64'(got.byte_class));
      end else begin
        want = awaited_results.pop_front();
        if (got.byte_class !== want.byte_class)
          report_mismatch("byte_class", 64'(want.byte_class), 64'(got.byte_class));
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", 64'(want.data_out), 64'(got.data_out));
        if (got.fin !== want.fin)
          report_mismatch("fin", 64'(want.fin), 64'(got.fin));
        if (got.rsv_bits !== want.rsv_bits)
          report_mismatch("rsv_bits", 64'(want.rsv_bits), 64'(got.rsv_bits));
        if (got.opcode !== want.opcode)
          report_mismatch("opcode", 64'(want.opcode), 64'(got.opcode));
        if (got.masked !== want.masked)
          report_mismatch("masked", 64'(want.masked), 64'(got.masked));
        if (got.payload_length !== want.payload_length)
          report_mismatch("payload_length", want.payload_length, got.payload_length);
        if (got.frame_end !== want.frame_end)
          report_mismatch("frame_end", 64'(want.frame_end), 64'(got.frame_end));
      end
    end
  end

  // The receiver decides afresh at every falling edge whether it will take a
  // result at the next rising edge.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Every stimulus task is entered just after a falling edge at which no
  // input has yet been assigned, and returns in the same condition. Valid is
  // therefore only ever given one value per time step.
  task automatic send_item(input cmd_t c, input logic [7:0] d);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.cmd     <= c;
    in_if.data_in <= d;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    deframe_byte(c, d);
    @(negedge clk);
  endtask

  task automatic send_octets(input octet_q_t octets);
    foreach (octets[i]) send_item(CMD_DATA, octets[i]);
  endtask

  // The sender holds off until the block has handed back everything it owes.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // Frames that end on a header byte, and a byte arriving after the end.
  task automatic test_zero_length_frames();
    // Unmasked ping with no payload ends on its second byte; the byte that
    // follows is dropped.
    send_octets({8'h89, 8'h00, 8'hFF});
    send_item(CMD_CLEAR, 8'h00);
    // A 16-bit extended length of zero ends on the last length byte.
    send_octets({8'h0A, 8'h7E, 8'h00, 8'h00});
    send_item(CMD_CLEAR, 8'hFF);
  endtask

  // All header flags set, a masked payload and key bytes at both extremes.
  task automatic test_masked_extremes();
    send_octets({8'hFF, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF});
    send_item(CMD_CLEAR, 8'h00);
  endtask

  // The largest 64-bit length; the frame is abandoned part way through its
  // payload by a clear.
  task automatic test_widest_length();
    send_octets({8'h01, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A});
    send_item(CMD_CLEAR, 8'h00);
  endtask

  // One generated frame followed by a clear. Most frames are complete and
  // well formed; some are cut short anywhere, some have trailing bytes after
  // the end, and a few are plain noise.
  task automatic random_frame();
    octet_q_t    octets;
    logic [63:0] len;
    logic [7:0]  len_byte;
    len_form_t   form;
    int unsigned pick;
    int unsigned n_pay;
    bit          mask;
    bit          cut;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(6, 1)) send_item(cmd_t'($urandom_range(1)), 8'($urandom));
      send_item(CMD_CLEAR, 8'($urandom));
    end else begin
      cut  = ($urandom_range(99) < 12);
      mask = 1'($urandom_range(1));
      pick = $urandom_range(99);
      form = (pick < 70) ? LEN_SHORT : (pick < 88) ? LEN_EXT16 : LEN_EXT64;
      case (form)
        LEN_SHORT: begin
          len = ($urandom_range(99) < 6) ? 64'($urandom_range(125))
                                         : 64'($urandom_range(10));
          len_byte = {mask, len[6:0]};
        end
        LEN_EXT16: begin
          // Only a frame that is cut short may carry a length it never reaches.
          len = cut ? 64'($urandom_range(16'hFFFF)) : 64'($urandom_range(24));
          len_byte = {mask, BASE_LEN_EXT16};
        end
        default: begin
          len = cut ? {32'($urandom), 32'($urandom)} : 64'($urandom_range(24));
          len_byte = {mask, BASE_LEN_EXT64};
        end
      endcase
      octets.push_back(8'($urandom));
      octets.push_back(len_byte);
      if (form == LEN_EXT16) begin
        for (int i = 1; i >= 0; i--) octets.push_back(len[8*i +: 8]);
      end else if (form == LEN_EXT64) begin
        for (int i = 7; i >= 0; i--) octets.push_back(len[8*i +: 8]);
      end
      if (mask) repeat (4) octets.push_back(8'($urandom));
      n_pay = (cut && len > 64'd6) ? 6 : int'(len);
      repeat (n_pay) octets.push_back(8'($urandom));
      if (cut) begin
        pick = $urandom_range(octets.size() - 1);
        while (octets.size() > pick) void'(octets.pop_back());
      end else if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(3, 1)) octets.push_back(8'($urandom));
      end
      send_octets(octets);
      send_item(CMD_CLEAR, 8'($urandom));
    end
  endtask

  // Random traffic under one pair of idle rates, ended by a full drain.
  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned target;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    target = parsed_bytes + ITEMS_PER_PHASE;
    while (parsed_bytes < target) random_frame();
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.cmd     = CMD_DATA;
    in_if.data_in = 8'h00;
    out_if.ready  = 1'b0;
    clear_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct   = 36;
    receiver_idle_pct = 86;
    test_zero_length_frames();
    test_masked_extremes();
    test_widest_length();

    test_random_traffic(36, 86);
    test_random_traffic(86, 36);
    test_random_traffic(0, 0);

    // The wait below leaves room for a stray result to surface.
    repeat (4) @(negedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 64'd0, 64'(awaited_results.size()));

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Far beyond the slowest correct run, which needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
